@@ rtl/tsec_pkg.sv @@
// ----------------------------------------------------------------------------
// Threshold sweep error counter package
// Widths, command codes, shared types and saturating helpers.
// ----------------------------------------------------------------------------
package tsec_pkg;

    // Default number of threshold steps; bins run 0..DISTR_SIZE
    localparam int unsigned DISTR_SIZE_DEF = 16;

    // Field widths
    localparam int unsigned SCORE_W  = 18;
    localparam int unsigned TIME_W   = 40;
    localparam int unsigned BIN_W    = 6;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned SUM_W    = 48;

    // Scaled score: score * DISTR_SIZE with DISTR_SIZE up to 63, plus sign
    localparam int unsigned SCALED_W = SCORE_W + 7;

    // Q16 one
    localparam int unsigned ONE_Q16  = 65536;

    // Command codes
    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_DUMP  = 1'b1;

    // One scored sample as it travels to the bin lanes
    typedef struct packed {
        logic                      is_genuine;
        logic signed [SCORE_W-1:0] score;
        logic [TIME_W-1:0]         sample_time;
    } t_sample;

    // Counters of one bin
    typedef struct packed {
        logic [CNT_W-1:0] positive_count;
        logic [CNT_W-1:0] false_accepts;
        logic [CNT_W-1:0] false_rejects;
        logic [SUM_W-1:0] wait_sum;
    } t_bin_stats;

    // Saturating increment of a count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    // Saturating add of an interval to a wait sum
    function automatic logic [SUM_W-1:0] sat_add_wait(input logic [SUM_W-1:0] sum,
                                                      input logic [TIME_W-1:0] dt);
        logic [SUM_W:0] s;
        s = {1'b0, sum} + (SUM_W+1)'(dt);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

@@ rtl/tsec_if.sv @@
// ----------------------------------------------------------------------------
// Threshold sweep error counter channels
// Valid/ready channels for sample items and per-bin result items.
// ----------------------------------------------------------------------------
interface tsec_in_if;
    logic                                        valid;
    logic                                        ready;
    logic                                        command;
    logic signed [tsec_pkg::SCORE_W-1:0]         score;
    logic                                        is_genuine;
    logic [tsec_pkg::TIME_W-1:0]                 sample_time;

    modport source (output valid, command, score, is_genuine, sample_time,
                    input ready);
    modport sink   (input valid, command, score, is_genuine, sample_time,
                    output ready);
endinterface

interface tsec_out_if;
    logic                          valid;
    logic                          ready;
    logic [tsec_pkg::BIN_W-1:0]    bin_index;
    logic [tsec_pkg::CNT_W-1:0]    positive_count;
    logic [tsec_pkg::CNT_W-1:0]    false_accepts;
    logic [tsec_pkg::CNT_W-1:0]    false_rejects;
    logic [tsec_pkg::SUM_W-1:0]    wait_sum_seconds;
    logic [tsec_pkg::CNT_W-1:0]    sample_count;
    logic [tsec_pkg::CNT_W-1:0]    genuine_count;
    logic                          last;

    modport source (output valid, bin_index, positive_count, false_accepts,
                    false_rejects, wait_sum_seconds, sample_count, genuine_count,
                    last, input ready);
    modport sink   (input valid, bin_index, positive_count, false_accepts,
                    false_rejects, wait_sum_seconds, sample_count, genuine_count,
                    last, output ready);
endinterface

@@ rtl/tsec_bin_lane.sv @@
// ----------------------------------------------------------------------------
// Threshold bin lane
// Decision and counters for one threshold BIN_IDX / DISTR_SIZE.
// ----------------------------------------------------------------------------
module tsec_bin_lane #(
    parameter int unsigned DISTR_SIZE = tsec_pkg::DISTR_SIZE_DEF,
    parameter int unsigned BIN_IDX    = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_update,
    input  tsec_pkg::t_sample    i_sample,
    output tsec_pkg::t_bin_stats o_stats
);
    import tsec_pkg::*;

    localparam logic signed [SCALED_W-1:0] K_SCALE = SCALED_W'(DISTR_SIZE);
    localparam logic signed [SCALED_W-1:0] K_THR   = SCALED_W'(BIN_IDX * ONE_Q16);

    logic signed [SCALED_W-1:0] w_score_x;
    logic signed [SCALED_W-1:0] w_scaled;
    logic                       w_pos;
    logic [TIME_W-1:0]          w_dt;

    t_bin_stats        r_stats, n_stats;
    logic              r_last_valid, n_last_valid;
    logic [TIME_W-1:0] r_last_time;

    // score >= i/N done exactly as score*N >= i*65536
    assign w_score_x = SCALED_W'(i_sample.score);
    assign w_scaled  = w_score_x * K_SCALE;
    assign w_pos     = (w_scaled >= K_THR);

    // interval since previous positive, zero if time ran backwards
    assign w_dt = (i_sample.sample_time >= r_last_time) ?
                  i_sample.sample_time - r_last_time : '0;

    // counter updates
    always_comb begin
        n_stats      = r_stats;
        n_last_valid = r_last_valid;
        if (i_update) begin
            if (w_pos) begin
                if (r_last_valid) begin
                    n_stats.wait_sum = sat_add_wait(r_stats.wait_sum, w_dt);
                end
                n_last_valid           = 1'b1;
                n_stats.positive_count = sat_inc(r_stats.positive_count);
            end
            if (i_sample.is_genuine && !w_pos) begin
                n_stats.false_rejects = sat_inc(r_stats.false_rejects);
            end
            if (!i_sample.is_genuine && w_pos) begin
                n_stats.false_accepts = sat_inc(r_stats.false_accepts);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stats      <= '0;
            r_last_valid <= 1'b0;
        end else begin
            r_stats      <= n_stats;
            r_last_valid <= n_last_valid;
        end
    end

    // last positive time, guarded by r_last_valid
    always_ff @(posedge i_clk) begin
        if (i_update && w_pos) begin
            r_last_time <= i_sample.sample_time;
        end
    end

    assign o_stats = r_stats;

endmodule

@@ rtl/threshold_sweep_error_counter_top.sv @@
// ----------------------------------------------------------------------------
// Threshold sweep error counter
// Per-threshold positive, false-accept, false-reject and wait-time counters.
// ----------------------------------------------------------------------------
// An accumulate item is taken every cycle while no dump holds the input
// register: it waits in the input register and all DISTR_SIZE+1 bin lanes
// update together from it. A dump item holds the input register while the
// bins leave through the output register one per cycle when the output does
// not stall, lowest bin first, the last one flagged; the next item is taken
// in the cycle the last bin is loaded. Output stalls stretch a dump. Counters
// saturate and are cleared only by reset; a dump leaves them as they are.
module threshold_sweep_error_counter_top #(
    parameter int unsigned DISTR_SIZE = tsec_pkg::DISTR_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsec_in_if.sink    i_item,
    tsec_out_if.source o_result
);
    import tsec_pkg::*;

    localparam int unsigned NBINS = DISTR_SIZE + 1;
    localparam int unsigned IDX_W = $clog2(NBINS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DISTR_SIZE);

    // input register
    logic       r_in_valid;
    logic       r_cmd;
    t_sample    r_sample;

    // dump sequencing
    logic [IDX_W-1:0] r_dump_idx, n_dump_idx;

    // totals
    logic [CNT_W-1:0] r_total_samples, r_total_genuine;

    // output register
    logic             r_out_valid;
    logic [BIN_W-1:0] r_out_bin;
    t_bin_stats       r_out_stats;
    logic [CNT_W-1:0] r_out_samples, r_out_genuine;
    logic             r_out_last;

    logic       w_out_load_ok;
    logic       w_dump_issue;
    logic       w_dump_done;
    logic       w_acc_fire;
    logic       w_stage_free;
    logic       w_in_fire;
    t_bin_stats w_stats [NBINS];

    // stage control
    assign w_out_load_ok = !r_out_valid || o_result.ready;
    assign w_dump_issue  = r_in_valid && (r_cmd == CMD_DUMP) && w_out_load_ok;
    assign w_dump_done   = w_dump_issue && (r_dump_idx == LAST_IDX);
    assign w_acc_fire    = r_in_valid && (r_cmd == CMD_ACCUM);
    assign w_stage_free  = !r_in_valid || w_acc_fire || w_dump_done;
    assign i_item.ready  = w_stage_free;
    assign w_in_fire     = i_item.valid && w_stage_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_stage_free) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd                <= i_item.command;
            r_sample.is_genuine  <= i_item.is_genuine;
            r_sample.score       <= i_item.score;
            r_sample.sample_time <= i_item.sample_time;
        end
    end

    // bin lanes
    for (genvar g = 0; g < NBINS; g++) begin : g_bin
        tsec_bin_lane #(
            .DISTR_SIZE (DISTR_SIZE),
            .BIN_IDX    (g)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_update (w_acc_fire),
            .i_sample (r_sample),
            .o_stats  (w_stats[g])
        );
    end

    // totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_samples <= '0;
            r_total_genuine <= '0;
        end else if (w_acc_fire) begin
            r_total_samples <= sat_inc(r_total_samples);
            if (r_sample.is_genuine) begin
                r_total_genuine <= sat_inc(r_total_genuine);
            end
        end
    end

    // dump bin counter
    always_comb begin
        n_dump_idx = r_dump_idx;
        if (w_dump_issue) begin
            n_dump_idx = w_dump_done ? '0 : r_dump_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dump_idx <= '0;
        end else begin
            r_dump_idx <= n_dump_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_dump_issue) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dump_issue) begin
            r_out_bin     <= BIN_W'(r_dump_idx);
            r_out_stats   <= w_stats[r_dump_idx];
            r_out_samples <= r_total_samples;
            r_out_genuine <= r_total_genuine;
            r_out_last    <= (r_dump_idx == LAST_IDX);
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.bin_index        = r_out_bin;
    assign o_result.positive_count   = r_out_stats.positive_count;
    assign o_result.false_accepts    = r_out_stats.false_accepts;
    assign o_result.false_rejects    = r_out_stats.false_rejects;
    assign o_result.wait_sum_seconds = r_out_stats.wait_sum;
    assign o_result.sample_count     = r_out_samples;
    assign o_result.genuine_count    = r_out_genuine;
    assign o_result.last             = r_out_last;

endmodule

@@ rtl/tsec_checker.sv @@
// ----------------------------------------------------------------------------
// Threshold sweep error counter checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module tsec_checker #(
    parameter int unsigned DISTR_SIZE = tsec_pkg::DISTR_SIZE_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [tsec_pkg::BIN_W-1:0] i_bin_index,
    input logic [tsec_pkg::CNT_W-1:0] i_sample_count,
    input logic                       i_last
);
    import tsec_pkg::*;

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(DISTR_SIZE);

    logic w_out_acc;
    assign w_out_acc = i_out_valid && i_out_ready;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_bin_index) && $stable(i_last))
        else $error("stalled result changed");

    // last flag marks exactly the top bin
    a_last_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_bin_index == LAST_BIN)))
        else $error("last flag on wrong bin");

    // bins of a dump follow back to back in rising order
    a_bin_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !i_last |=>
            i_out_valid && (i_bin_index == $past(i_bin_index) + BIN_W'(1)))
        else $error("dump bins out of order");

    // sample total stays fixed within one dump
    a_dump_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !i_last |=> i_sample_count == $past(i_sample_count))
        else $error("sample total changed within dump");

endmodule

bind threshold_sweep_error_counter_top tsec_checker #(
    .DISTR_SIZE (DISTR_SIZE)
) u_tsec_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_bin_index    (o_result.bin_index),
    .i_sample_count (o_result.sample_count),
    .i_last         (o_result.last)
);
